### rtl/psfp_pkg.sv
// ----------------------------------------------------------------------------
// psfp_pkg
// Shared types and constants of the particle sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package psfp_pkg;

  // Frame header bytes
  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;

  // Accepted frame lengths (9 or 13 data words plus the checksum word)
  localparam logic [15:0] LEN_SHORT = 16'(2 * 9 + 2);
  localparam logic [15:0] LEN_LONG  = 16'(2 * 13 + 2);

  // Byte position counter
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_HDR1   = 5'd0;
  localparam logic [POS_W-1:0] POS_HDR2   = 5'd1;
  localparam logic [POS_W-1:0] POS_LEN_HI = 5'd2;
  localparam logic [POS_W-1:0] POS_LEN_LO = 5'd3;
  localparam logic [POS_W-1:0] POS_DATA   = 5'd4;

  // Checksum byte positions for each frame length
  localparam logic [POS_W-1:0] POS_CKS_HI_SHORT = POS_W'(LEN_SHORT + 16'd2);
  localparam logic [POS_W-1:0] POS_CKS_LO_SHORT = POS_W'(LEN_SHORT + 16'd3);
  localparam logic [POS_W-1:0] POS_CKS_HI_LONG  = POS_W'(LEN_LONG + 16'd2);
  localparam logic [POS_W-1:0] POS_CKS_LO_LONG  = POS_W'(LEN_LONG + 16'd3);

  // Stored payload and readings
  localparam int unsigned PAYLOAD_DEPTH = 12;
  localparam int unsigned PAYLOAD_IDX_W = 4;
  localparam logic [POS_W-1:0] POS_DATA_END = POS_W'(4 + PAYLOAD_DEPTH);
  localparam int unsigned NUM_READINGS  = 6;
  localparam int unsigned READING_W     = 16;

  typedef logic [NUM_READINGS-1:0][READING_W-1:0] readings_t;

  // One result transaction
  typedef struct packed {
    logic      checksum_ok;
    readings_t readings;
  } result_t;

endpackage : psfp_pkg

`default_nettype wire

### rtl/psfp_if.sv
// ----------------------------------------------------------------------------
// psfp_if
// Valid/ready channels of the particle sensor frame parser: byte input and
// result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface psfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : psfp_in_if

interface psfp_out_if
  import psfp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 checksum_ok;
  logic [READING_W-1:0] std_pm1_0;
  logic [READING_W-1:0] std_pm2_5;
  logic [READING_W-1:0] std_pm10;
  logic [READING_W-1:0] atm_pm1_0;
  logic [READING_W-1:0] atm_pm2_5;
  logic [READING_W-1:0] atm_pm10;

  modport source (output valid, output checksum_ok, output std_pm1_0, output std_pm2_5,
                  output std_pm10, output atm_pm1_0, output atm_pm2_5, output atm_pm10,
                  input ready);
  modport sink   (input valid, input checksum_ok, input std_pm1_0, input std_pm2_5,
                  input std_pm10, input atm_pm1_0, input atm_pm2_5, input atm_pm10,
                  output ready);
endinterface : psfp_out_if

`default_nettype wire

### rtl/psfp_parser.sv
// ----------------------------------------------------------------------------
// psfp_parser
// Frame state tracker: consumes one byte per step, keeps the running sum,
// payload bytes and latched readings, and flags a result on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module psfp_parser
  import psfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output logic            emit,
  output result_t         result
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [7:0]        len_hi_r, len_hi_nxt;
  logic              long_r, long_nxt;
  logic [7:0]        cks_hi_r, cks_hi_nxt;
  readings_t         readings_r, readings_nxt;
  logic [7:0]        payload_r [PAYLOAD_DEPTH];
  logic              payload_we;
  logic [PAYLOAD_IDX_W-1:0] payload_idx;
  logic [POS_W-1:0]  pos_off;
  logic [15:0]       frame_len;
  logic [POS_W-1:0]  pos_cks_hi, pos_cks_lo;
  logic              sum_match;
  readings_t         payload_words;

  // Derived positions and compare
  assign frame_len   = {len_hi_r, rx_byte};
  assign pos_cks_hi  = long_r ? POS_CKS_HI_LONG : POS_CKS_HI_SHORT;
  assign pos_cks_lo  = long_r ? POS_CKS_LO_LONG : POS_CKS_LO_SHORT;
  assign sum_match   = ({cks_hi_r, rx_byte} == sum_r);
  assign pos_off     = pos_r - POS_DATA;
  assign payload_idx = pos_off[PAYLOAD_IDX_W-1:0];

  // Big-endian words from stored payload
  always_comb begin
    for (int i = 0; i < NUM_READINGS; i++) begin
      payload_words[i] = {payload_r[2*i], payload_r[2*i+1]};
    end
  end

  // Per-byte next state
  always_comb begin
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    len_hi_nxt   = len_hi_r;
    long_nxt     = long_r;
    cks_hi_nxt   = cks_hi_r;
    readings_nxt = readings_r;
    payload_we   = 1'b0;
    emit         = 1'b0;
    case (pos_r)
      POS_HDR1: begin
        if (rx_byte == HDR_FIRST) begin
          sum_nxt = {8'd0, rx_byte};
          pos_nxt = POS_HDR2;
        end
      end
      POS_HDR2: begin
        if (rx_byte == HDR_SECOND) begin
          sum_nxt = sum_r + {8'd0, rx_byte};
          pos_nxt = POS_LEN_HI;
        end else begin
          pos_nxt = POS_HDR1;
        end
      end
      POS_LEN_HI: begin
        sum_nxt    = sum_r + {8'd0, rx_byte};
        len_hi_nxt = rx_byte;
        pos_nxt    = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        if (frame_len == LEN_SHORT || frame_len == LEN_LONG) begin
          sum_nxt  = sum_r + {8'd0, rx_byte};
          long_nxt = (frame_len == LEN_LONG);
          pos_nxt  = POS_DATA;
        end else begin
          pos_nxt = POS_HDR1;
        end
      end
      default: begin
        if (pos_r == pos_cks_hi) begin
          cks_hi_nxt = rx_byte;
          pos_nxt    = pos_r + 5'd1;
        end else if (pos_r == pos_cks_lo) begin
          emit    = 1'b1;
          pos_nxt = POS_HDR1;
          if (sum_match) begin
            readings_nxt = payload_words;
          end
        end else begin
          sum_nxt    = sum_r + {8'd0, rx_byte};
          payload_we = (pos_r < POS_DATA_END);
          pos_nxt    = pos_r + 5'd1;
        end
      end
    endcase
  end

  // Result follows the updated latch
  assign result.checksum_ok = sum_match;
  assign result.readings    = readings_nxt;

  // Control state and latched readings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_HDR1;
      sum_r      <= '0;
      len_hi_r   <= '0;
      long_r     <= 1'b0;
      cks_hi_r   <= '0;
      readings_r <= '0;
    end else if (step) begin
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      len_hi_r   <= len_hi_nxt;
      long_r     <= long_nxt;
      cks_hi_r   <= cks_hi_nxt;
      readings_r <= readings_nxt;
    end
  end

  // Payload byte store
  always_ff @(posedge clk) begin
    if (step && payload_we) begin
      payload_r[payload_idx] <= rx_byte;
    end
  end

endmodule : psfp_parser

`default_nettype wire

### rtl/particle_sensor_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser_unit
// Parses particulate sensor frames byte by byte and reports the checksum
// status with the six latched concentrations at the end of each frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Payload
//  in_chan   sink       valid/ready    rx_byte[7:0]
//  out_chan  source     valid/ready    checksum_ok, std_pm1_0..atm_pm10 [15:0]
//
//  The parser takes one byte per clock unless a held result stalls it; a byte
//  reaches the parser in the cycle after acceptance, and its result (last
//  checksum byte only) then goes through the result register to out_chan.
//  rst_n is synchronous, active low; it returns the parser to header hunting
//  and clears the latched readings.
//  A held result stalls the parser stage; the input register then fills and
//  in_chan.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_sensor_frame_parser_unit
  import psfp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  psfp_in_if.sink     in_chan,
  psfp_out_if.source  out_chan
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       emit;
  result_t    result;
  logic       out_valid_r;
  result_t    out_data_r;

  // Parser stage moves when the result register can take a transaction
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.rx_byte;
    end
  end

  psfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .emit    (emit),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.checksum_ok = out_data_r.checksum_ok;
  assign out_chan.std_pm1_0   = out_data_r.readings[0];
  assign out_chan.std_pm2_5   = out_data_r.readings[1];
  assign out_chan.std_pm10    = out_data_r.readings[2];
  assign out_chan.atm_pm1_0   = out_data_r.readings[3];
  assign out_chan.atm_pm2_5   = out_data_r.readings[4];
  assign out_chan.atm_pm10    = out_data_r.readings[5];

endmodule : particle_sensor_frame_parser_unit

`default_nettype wire

### rtl/psfp_checker.sv
// ----------------------------------------------------------------------------
// psfp_checker
// Port-level checks on the particle sensor frame parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module psfp_checker
  import psfp_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 checksum_ok,
  input wire logic [READING_W-1:0] std_pm1_0,
  input wire logic [READING_W-1:0] std_pm2_5,
  input wire logic [READING_W-1:0] std_pm10,
  input wire logic [READING_W-1:0] atm_pm1_0,
  input wire logic [READING_W-1:0] atm_pm2_5,
  input wire logic [READING_W-1:0] atm_pm10
);

  readings_t cur_readings;
  readings_t last_readings_r;
  logic      out_fire;

  assign cur_readings = {atm_pm10, atm_pm2_5, atm_pm1_0, std_pm10, std_pm2_5, std_pm1_0};
  assign out_fire     = out_valid && out_ready;

  // Readings of the last delivered transaction (reset value is all zero)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_readings_r <= '0;
    end else if (out_fire) begin
      last_readings_r <= cur_readings;
    end
  end

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(checksum_ok) && $stable(cur_readings))
    else $error("result payload changed while stalled");

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A failed checksum repeats the previous readings
  a_mismatch_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !checksum_ok |-> cur_readings == last_readings_r)
    else $error("readings changed on checksum mismatch");

  // A result needs a byte accepted ahead of it, through the input and result registers
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding byte");

endmodule : psfp_checker

bind particle_sensor_frame_parser_unit psfp_checker u_psfp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .checksum_ok (out_chan.checksum_ok),
  .std_pm1_0   (out_chan.std_pm1_0),
  .std_pm2_5   (out_chan.std_pm2_5),
  .std_pm10    (out_chan.std_pm10),
  .atm_pm1_0   (out_chan.atm_pm1_0),
  .atm_pm2_5   (out_chan.atm_pm2_5),
  .atm_pm10    (out_chan.atm_pm10)
);

`default_nettype wire

### sim/tb_particle_sensor_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_particle_sensor_frame_parser_unit
// Byte stream test of the particle sensor frame parser. Good frames of both
// lengths, bad checksums, bad lengths, broken headers and line noise go in
// with random gaps. A byte-level model predicts each result, and the monitor
// checks every result field against it under random output stalls.
// ----------------------------------------------------------------------------

module tb_particle_sensor_frame_parser_unit;
  import psfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Marks a point where the sender holds off until all results are in
  localparam int HOLD_MARK = -1;

  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic clk;
  logic rst_n;

  psfp_in_if  in_if ();
  psfp_out_if out_if ();

  particle_sensor_frame_parser_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Byte stream to send, and results still owed by the parser
  int      rx_stream[$];
  result_t pending_reports[$];
  int      err_count = 0;

  // Frame tracker state
  logic [POS_W-1:0] frm_pos   = POS_HDR1;
  logic [15:0]      frm_sum   = '0;
  logic [15:0]      frm_len   = '0;
  logic [7:0]       cks_hi    = '0;
  logic [7:0]       payload[PAYLOAD_DEPTH];
  readings_t        held_conc = '0;

  // Idle control for both sides
  int send_gap   = 0;
  bit send_burst = 1'b0;
  int recv_stall = 0;
  bit recv_burst = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, a few long ones, none at all in a burst
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Advance the frame tracker by one accepted byte
  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] rx_sum;
    result_t     rep;
    case (frm_pos)
      POS_HDR1: begin
        if (b == HDR_FIRST) begin
          frm_sum = {8'h00, b};
          frm_pos = POS_HDR2;
        end
      end
      POS_HDR2: begin
        // a mismatch is not rechecked as a first header byte
        if (b == HDR_SECOND) begin
          frm_sum += b;
          frm_pos = POS_LEN_HI;
        end else begin
          frm_pos = POS_HDR1;
        end
      end
      POS_LEN_HI: begin
        frm_sum += b;
        frm_len = {b, 8'h00};
        frm_pos = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        frm_len[7:0] = b;
        if (frm_len != LEN_SHORT && frm_len != LEN_LONG) begin
          frm_pos = POS_HDR1;
        end else begin
          frm_sum += b;
          frm_pos = POS_DATA;
        end
      end
      default: begin
        if (16'(frm_pos) == frm_len + 16'd2) begin
          cks_hi = b;
          frm_pos++;
        end else if (16'(frm_pos) == frm_len + 16'd3) begin
          rx_sum = {cks_hi, b};
          // readings reload only on a checksum match
          if (rx_sum == frm_sum) begin
            for (int k = 0; k < NUM_READINGS; k++)
              held_conc[k] = {payload[2*k], payload[2*k+1]};
          end
          rep.checksum_ok = (rx_sum == frm_sum);
          rep.readings    = held_conc;
          pending_reports.push_back(rep);
          frm_pos = POS_HDR1;
        end else begin
          frm_sum += b;
          if (frm_pos < POS_DATA_END) payload[frm_pos - POS_DATA] = b;
          frm_pos++;
        end
      end
    endcase
  endtask

  // Queue one frame; a length other than the two accepted ones gets a few
  // trailing bytes and no checksum
  task automatic push_frame(input logic [15:0] len_field, input bit bad_sum,
                            input fill_t fill);
    logic [15:0] sum;
    logic [7:0]  b;
    int          n;
    bit          good_len;
    good_len = (len_field == LEN_SHORT) || (len_field == LEN_LONG);
    sum = 16'(HDR_FIRST) + 16'(HDR_SECOND) + 16'(len_field[15:8]) + 16'(len_field[7:0]);
    rx_stream.push_back(int'(HDR_FIRST));
    rx_stream.push_back(int'(HDR_SECOND));
    rx_stream.push_back(int'(len_field[15:8]));
    rx_stream.push_back(int'(len_field[7:0]));
    n = good_len ? int'(len_field) - 2 : $urandom_range(0, 6);
    for (int k = 0; k < n; k++) begin
      case (fill)
        FILL_ONES:  b = 8'hFF;
        FILL_ZEROS: b = 8'h00;
        default:    b = 8'($urandom_range(0, 255));
      endcase
      sum += b;
      rx_stream.push_back(int'(b));
    end
    if (good_len) begin
      if (bad_sum) sum ^= 16'($urandom_range(1, 65535));
      rx_stream.push_back(int'(sum[15:8]));
      rx_stream.push_back(int'(sum[7:0]));
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%04h, got 0x%04h", name, want, got);
      err_count++;
    end
  endtask

  // Byte driver: tracks accepted bytes, then loads the next one
  always @(posedge clk) begin : byte_driver
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.rx_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) parse_byte(in_if.rx_byte);
      if (!in_if.valid || in_if.ready) begin
        if (rx_stream.size() > 0 && rx_stream[0] == HOLD_MARK && pending_reports.size() == 0)
          void'(rx_stream.pop_front());
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (rx_stream.size() > 0 && rx_stream[0] != HOLD_MARK) begin
          in_if.valid   <= 1'b1;
          in_if.rx_byte <= 8'(rx_stream.pop_front());
          send_gap = pick_gap(send_burst);
          if ($urandom_range(0, 149) == 0) send_burst = !send_burst;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_reports.size() == 0) begin
          $error("result transaction with none expected");
          err_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("checksum_ok", 16'(want.checksum_ok), 16'(out_if.checksum_ok));
          check_field("std_pm1_0", want.readings[0], out_if.std_pm1_0);
          check_field("std_pm2_5", want.readings[1], out_if.std_pm2_5);
          check_field("std_pm10",  want.readings[2], out_if.std_pm10);
          check_field("atm_pm1_0", want.readings[3], out_if.atm_pm1_0);
          check_field("atm_pm2_5", want.readings[4], out_if.atm_pm2_5);
          check_field("atm_pm10",  want.readings[5], out_if.atm_pm10);
        end
        recv_stall = pick_gap(recv_burst);
        if ($urandom_range(0, 7) == 0) recv_burst = !recv_burst;
      end else if (!out_if.valid && recv_stall == 0 && !recv_burst
                   && $urandom_range(0, 15) == 0) begin
        // stall ahead of a result too, so it can land on a low ready
        recv_stall = $urandom_range(1, 6);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int r;
    int waited;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;

    // Directed: noise extremes, broken header, bad lengths, good and bad frames
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(int'(HDR_FIRST));
    rx_stream.push_back(int'(HDR_FIRST));
    rx_stream.push_back(int'(HDR_SECOND));
    push_frame(16'h0015, 1'b0, FILL_RANDOM);
    push_frame(16'h0114, 1'b0, FILL_RANDOM);
    push_frame(LEN_SHORT, 1'b0, FILL_ONES);
    push_frame(LEN_LONG,  1'b1, FILL_ZEROS);
    push_frame(LEN_LONG,  1'b0, FILL_ZEROS);
    push_frame(LEN_SHORT, 1'b0, FILL_RANDOM);
    rx_stream.push_back(HOLD_MARK);

    // Random: mostly well-formed frames, the rest broken or noise
    while (rx_stream.size() < 1450) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        push_frame($urandom_range(0, 1) ? LEN_LONG : LEN_SHORT, 1'b0, FILL_RANDOM);
      end else if (r < 72) begin
        push_frame($urandom_range(0, 1) ? LEN_LONG : LEN_SHORT, 1'b1, FILL_RANDOM);
      end else if (r < 80) begin
        push_frame(16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                       : (LEN_SHORT ^ (16'd1 << $urandom_range(0, 15)))),
                   1'b0, FILL_RANDOM);
      end else if (r < 88) begin
        rx_stream.push_back(int'(HDR_FIRST));
        rx_stream.push_back($urandom_range(0, 255));
      end else if (r < 97) begin
        repeat ($urandom_range(1, 4)) rx_stream.push_back($urandom_range(0, 255));
      end else if (r < 99) begin
        // truncated frame: the next bytes get absorbed into it
        rx_stream.push_back(int'(HDR_FIRST));
        rx_stream.push_back(int'(HDR_SECOND));
        rx_stream.push_back(8'h00);
        rx_stream.push_back(int'(LEN_SHORT));
        repeat ($urandom_range(0, 10)) rx_stream.push_back($urandom_range(0, 255));
      end else begin
        rx_stream.push_back(HOLD_MARK);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // look after the driver's updates have settled for this edge
    while (rx_stream.size() > 0 || in_if.valid) begin
      @(posedge clk);
      #1;
    end
    waited = 0;
    while (pending_reports.size() > 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_reports.size() > 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb_particle_sensor_frame_parser_unit: done, clean");
    end else begin
      $display("tb_particle_sensor_frame_parser_unit: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("tb_particle_sensor_frame_parser_unit: done, errors");
    $finish;
  end

endmodule : tb_particle_sensor_frame_parser_unit
